// ===== design/dc_blocker_dual_moving_average_unit_assert.svh =====
// Assertion macros used by the DC blocker top-level design file.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef DC_BLOCKER_DUAL_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define DC_BLOCKER_DUAL_MOVING_AVERAGE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define DCB_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define DCB_ASSERT_IMP(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);
`define DCB_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);
`else
`define DCB_ASSERT(lbl, cond, msg)
`define DCB_ASSERT_IMP(lbl, trig, cond, msg)
`define DCB_ASSERT_NEXT(lbl, trig, cond, msg)
`endif
`endif

// ===== design/dcb_pkg.sv =====
// Types and fixed widths for the two-stage moving-average DC blocker.
// No dependencies.
package dcb_pkg;

	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = 21;
	localparam int OUT_W    = 17;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic signed [OUT_W-1:0]    out_t;

endpackage

// ===== design/dcb_delay_ram.sv =====
// Delay line memory: read-first synchronous RAM with registered read data.
// Entries read before the first full lap return zero. Depends on dcb_pkg.
module dcb_delay_ram import dcb_pkg::*; #(
	parameter int DEPTH = 31
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  acc,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  sample_t                               wdata,
	output sample_t                               rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	sample_t mem_q [DEPTH];
	sample_t rdata_q;
	logic    full_q;
	logic    rvalid_q;

	always_ff @(posedge clk) begin
		if (acc) begin
			rdata_q     <= mem_q[addr];
			mem_q[addr] <= wdata;
		end
	end

	// mark the line as filled once the last entry has been written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q   <= 1'b0;
			rvalid_q <= 1'b0;
		end else if (acc) begin
			rvalid_q <= full_q;
			if (addr == LAST_ADDR) begin
				full_q <= 1'b1;
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

// ===== design/dc_blocker_dual_moving_average_unit.sv =====
// An accepted word passes through the s1, s2 and s3 stage registers to the output register.
// Throughput: one word per cycle unless out_stall fills the pipeline; set by each delay RAM's read-modify-write.
// Bubbles collapse, so words are taken while a result waits on the output.
// Reset clears sums, delayed-tap registers, write pointer and stage valids; the RAMs are not
// swept, entries read before their first write return zero.
// Depends on dcb_pkg, dcb_delay_ram and the assertion macro header.
`include "dc_blocker_dual_moving_average_unit_assert.svh"
module dc_blocker_dual_moving_average_unit import dcb_pkg::*; #(
	parameter int LENGTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] sample_in,
	input  logic        last_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [16:0] sample_out,
	output logic        last_out
);

	localparam int LINE_DEPTH = LENGTH - 1;
	localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int SHIFT      = $clog2(LENGTH + 1) - 1;
	localparam logic [AW-1:0] LAST_POS = AW'(LINE_DEPTH - 1);

	logic          acc;
	logic          en1, en2, en3, en4;
	logic [AW-1:0] pos_q, pos_nx;

	logic          v_s1, v_s2, v_s3;
	sample_t       x_s1;
	logic          last_s1, last_s2, last_s3;
	logic [AW-1:0] pos_s1, pos_s2;
	sample_t       avg1_s2, avg1_s3;
	sample_t       tap_s2, tap_s3;

	sample_t       rd1, rd2;
	sample_t       dly1_q, dly2_q;
	sum_t          sum1_q, sum2_q, sum1_nx, sum2_nx;

	logic          out_valid_q;
	out_t          out_q;
	logic          last_q;

	assign en4      = !out_valid_q || !out_stall;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;
	assign acc      = in_valid && en1;

	assign pos_nx = (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;

	dcb_delay_ram #(.DEPTH(LINE_DEPTH)) u_line1 (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.addr   (pos_q),
		.wdata  (sample_t'(sample_in)),
		.rdata  (rd1)
	);

	dcb_delay_ram #(.DEPTH(LINE_DEPTH)) u_line2 (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (v_s2 && en3),
		.addr   (pos_s2),
		.wdata  (avg1_s2),
		.rdata  (rd2)
	);

	assign sum1_nx = sum1_q + SUM_W'(x_s1) - SUM_W'(dly1_q);
	assign sum2_nx = sum2_q + SUM_W'(avg1_s3) - SUM_W'(dly2_q);

	// control and averager state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
			sum1_q      <= '0;
			sum2_q      <= '0;
			dly1_q      <= '0;
			dly2_q      <= '0;
		end else begin
			if (acc) begin
				pos_q <= pos_nx;
			end
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				out_valid_q <= v_s3;
			end
			if (v_s1 && en2) begin
				sum1_q <= sum1_nx;
				dly1_q <= rd1;
			end
			if (v_s3 && en4) begin
				sum2_q <= sum2_nx;
				dly2_q <= rd2;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (acc) begin
			x_s1    <= sample_t'(sample_in);
			last_s1 <= last_in;
			pos_s1  <= pos_q;
		end
		if (v_s1 && en2) begin
			avg1_s2 <= sample_t'(sum1_nx >>> SHIFT);
			tap_s2  <= rd1;
			last_s2 <= last_s1;
			pos_s2  <= pos_s1;
		end
		if (v_s2 && en3) begin
			avg1_s3 <= avg1_s2;
			tap_s3  <= tap_s2;
			last_s3 <= last_s2;
		end
		if (v_s3 && en4) begin
			out_q  <= OUT_W'(tap_s3) - OUT_W'(sum2_nx >>> SHIFT);
			last_q <= last_s3;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;
	assign last_out   = last_q;

	`DCB_ASSERT(a_pos_range, pos_q <= LAST_POS, "write pointer beyond delay line")
	`DCB_ASSERT_IMP(a_stall_full, in_stall, v_s1 && v_s2 && v_s3 && out_valid_q, "bubble under stall")
	`DCB_ASSERT_NEXT(a_acc_s1, acc, v_s1, "accepted word missing from first stage")
	`DCB_ASSERT_NEXT(a_pos_step, acc, pos_q == $past(pos_nx), "write pointer did not advance")
	`DCB_ASSERT_NEXT(a_out_hold, out_valid_q && out_stall, out_valid_q && $stable({out_q, last_q}), "held word lost")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for dc_blocker_dual_moving_average_unit (LENGTH 32).
// Drives a directed table, then random segments; checks tabled or predicted words.
// Depends on dcb_pkg and the DUT sources only.
`timescale 1ns / 100ps

module tb_top;
	import dcb_pkg::*;

	localparam int AVG_LEN     = 32;
	localparam int LINE_DEPTH  = AVG_LEN - 1;
	localparam int AVG_SHIFT   = $clog2(AVG_LEN);
	localparam int TOTAL_WORDS = 1550;
	localparam int HOLD_AT     = 600;
	localparam int HOLD_CYCLES = 150;
	localparam int PAUSE_AT    = 900;
	localparam int QUIET_AT    = 1400;
	localparam int LIMIT       = 200000;
	localparam int N_ROWS      = 20;

	typedef enum int {SEG_NOISE, SEG_DC, SEG_STEP, SEG_SQUARE, SEG_RAMP} seg_kind_t;

	typedef struct {
		sample_t smp;
		logic    lst;
		bit      typed;
		out_t    want;
	} dir_row_t;

	typedef struct {
		out_t smp;
		logic lst;
	} filtered_word_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] sample_in;
	logic        last_in;
	logic        out_valid;
	logic        out_stall;
	logic [16:0] sample_out;
	logic        last_out;

	sample_t        line_a [LINE_DEPTH];
	sample_t        line_b [LINE_DEPTH];
	sample_t        tap_a, older_a, tap_b, older_b;
	sum_t           sum_a, sum_b;
	int             wr_pos;
	filtered_word_t filtered_q [$];
	filtered_word_t head_word;
	int             errors;
	int             words_sent;
	int             cycles;
	bit             bursty;
	bit             tail_quiet;
	bit             hold_request;

	dir_row_t directed_rows [N_ROWS] = '{
		'{16'sh0000, 1'b0, 1'b1, 17'sd0},
		'{16'sh0000, 1'b1, 1'b1, 17'sd0},
		'{16'sh0000, 1'b0, 1'b1, 17'sd0},
		'{16'sh7FFF, 1'b0, 1'b1, -17'sd31},
		'{16'sh8000, 1'b1, 1'b1, -17'sd31},
		'{16'sh7FFF, 1'b0, 1'b0, 17'sd0},
		'{16'sh7FFF, 1'b0, 1'b0, 17'sd0},
		'{16'sh7FFF, 1'b1, 1'b0, 17'sd0},
		'{16'sh8000, 1'b0, 1'b0, 17'sd0},
		'{16'sh8000, 1'b0, 1'b0, 17'sd0},
		'{16'sh8000, 1'b1, 1'b0, 17'sd0},
		'{16'sh0001, 1'b0, 1'b0, 17'sd0},
		'{16'shFFFF, 1'b0, 1'b0, 17'sd0},
		'{16'sh5555, 1'b1, 1'b0, 17'sd0},
		'{16'shAAAA, 1'b0, 1'b0, 17'sd0},
		'{16'sh7FFE, 1'b0, 1'b0, 17'sd0},
		'{16'sh8001, 1'b1, 1'b0, 17'sd0},
		'{16'sh00FF, 1'b0, 1'b0, 17'sd0},
		'{16'shFF00, 1'b0, 1'b0, 17'sd0},
		'{16'sh0000, 1'b1, 1'b0, 17'sd0}
	};

	dc_blocker_dual_moving_average_unit #(
		.LENGTH(AVG_LEN)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_in (sample_in),
		.last_in   (last_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample_out(sample_out),
		.last_out  (last_out)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// two cascaded 32-sample averagers; result is the delayed input minus the second average
	task automatic dc_block_step(input sample_t x, output out_t y);
		sample_t avg_a;
		sum_t    avg_b;
		older_a = tap_a;
		tap_a = line_a[wr_pos];
		line_a[wr_pos] = x;
		sum_a = sum_a + sum_t'(x) - sum_t'(older_a);
		avg_a = sample_t'(sum_a >>> AVG_SHIFT);
		older_b = tap_b;
		tap_b = line_b[wr_pos];
		line_b[wr_pos] = avg_a;
		sum_b = sum_b + sum_t'(avg_a) - sum_t'(older_b);
		avg_b = sum_b >>> AVG_SHIFT;
		wr_pos = (wr_pos == LINE_DEPTH - 1) ? 0 : wr_pos + 1;
		y = out_t'(sum_t'(tap_a) - avg_b);
	endtask

	task automatic offer_word(input sample_t s, input logic l, input bit typed, input out_t want);
		out_t           y;
		filtered_word_t w;
		@(negedge clk);
		if (bursty && !tail_quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= s;
		last_in   <= l;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		dc_block_step(s, y);
		w.smp = typed ? want : y;
		w.lst = l;
		filtered_q.push_back(w);
		words_sent++;
	endtask

	function automatic sample_t pick_level();
		case ($urandom_range(0, 3))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return sample_t'($urandom);
		endcase
	endfunction

	initial begin
		seg_kind_t kind;
		int        len;
		int        half;
		sample_t   lvl_a, lvl_b, s;
		in_valid     = 1'b0;
		sample_in    = '0;
		last_in      = 1'b0;
		arst_n       = 1'b0;
		errors       = 0;
		words_sent   = 0;
		bursty       = 1'b1;
		tail_quiet   = 1'b0;
		hold_request = 1'b0;
		tap_a = '0; older_a = '0; tap_b = '0; older_b = '0;
		sum_a = '0; sum_b = '0; wr_pos = 0;
		for (int i = 0; i < LINE_DEPTH; i++) begin
			line_a[i] = '0;
			line_b[i] = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			offer_word(directed_rows[i].smp, directed_rows[i].lst, directed_rows[i].typed,
				directed_rows[i].want);

		while (words_sent < TOTAL_WORDS) begin
			kind  = seg_kind_t'($urandom_range(0, 4));
			len   = $urandom_range(8, 96);
			half  = $urandom_range(2, 48);
			lvl_a = pick_level();
			lvl_b = pick_level();
			bursty = $urandom_range(0, 2) != 0;
			for (int i = 0; i < len && words_sent < TOTAL_WORDS; i++) begin
				if (words_sent == HOLD_AT)
					hold_request = 1'b1;
				if (words_sent == PAUSE_AT) begin
					@(negedge clk);
					in_valid <= 1'b0;
					while (filtered_q.size() != 0)
						@(posedge clk);
				end
				if (words_sent >= QUIET_AT)
					tail_quiet = 1'b1;
				case (kind)
					SEG_NOISE:  s = sample_t'($urandom);
					SEG_DC:     s = ($urandom_range(0, 3) == 0) ?
						lvl_a ^ sample_t'($urandom_range(0, 3)) : lvl_a;
					SEG_STEP:   s = (i < len / 2) ? lvl_a : lvl_b;
					SEG_SQUARE: s = ((i / half) % 2) ? lvl_b : lvl_a;
					default:    s = lvl_a + sample_t'(i * half * 37);
				endcase
				offer_word(s, $urandom_range(0, 15) == 0, 1'b0, '0);
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (filtered_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("** dc_blocker_dual_moving_average_unit: PASSED **");
		else
			$display("** dc_blocker_dual_moving_average_unit: FAILED **");
		$finish;
	end

	// receiver: random stall bursts, calm stretches, one long hold-off on request
	initial begin
		int burst;
		int calm_left;
		bit calm;
		out_stall = 1'b0;
		burst     = 0;
		calm_left = 0;
		calm      = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
				hold_request = 1'b0;
			end else begin
				if (calm_left == 0) begin
					calm      = $urandom_range(0, 2) == 0;
					calm_left = $urandom_range(40, 200);
				end
				calm_left--;
				if (burst > 0) begin
					out_stall <= 1'b1;
					burst--;
				end else if (!tail_quiet && !calm && $urandom_range(0, 5) == 0) begin
					burst = $urandom_range(1, 6) - 1;
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (filtered_q.size() == 0) begin
				$error("unexpected output word: sample_out=%0d last_out=%0b",
					$signed(sample_out), last_out);
				errors++;
			end else begin
				head_word = filtered_q.pop_front();
				if (sample_out !== head_word.smp) begin
					$error("sample_out mismatch: expected %0d, actual %0d",
						head_word.smp, $signed(sample_out));
					errors++;
				end
				if (last_out !== head_word.lst) begin
					$error("last_out mismatch: expected %0b, actual %0b",
						head_word.lst, last_out);
					errors++;
				end
			end
		end
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("** dc_blocker_dual_moving_average_unit: FAILED **");
			$finish;
		end
	end

endmodule

// ===== files.f =====
+incdir+design
design/dcb_pkg.sv
design/dcb_delay_ram.sv
design/dc_blocker_dual_moving_average_unit.sv
verif/tb_top.sv
